// ===== design/assert_macros.svh =====
// Assertion macros shared by the frame decoder RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ACFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ACFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== design/acfd_pkg.sv =====
// Types and constants of the ASCII command frame decoder.
// No dependencies.
`default_nettype none

package acfd_pkg;

    localparam int unsigned NUM_KW   = 6;
    localparam int unsigned KW_MAX   = 5;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned CMD_W    = 3;

    typedef logic [7:0]          t_byte;
    typedef logic [LEN_W-1:0]    t_len;
    typedef logic [NUM_KW-1:0]   t_kw_mask;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [CMD_W-1:0]    t_cmd;

    localparam t_cmd CMD_BAD     = 3'd0;
    localparam t_cmd CMD_LED_ON  = 3'd1;
    localparam t_cmd CMD_LED_OFF = 3'd2;
    localparam t_cmd CMD_LOCK    = 3'd3;
    localparam t_cmd CMD_SLEEP   = 3'd4;
    localparam t_cmd CMD_PEOPLE  = 3'd5;
    localparam t_cmd CMD_FP_ID   = 3'd6;

    localparam t_byte END_MARK   = 8'd35;   // '#'
    localparam t_byte ASCII_ZERO = 8'd48;   // '0'
    localparam t_byte ASCII_NINE = 8'd57;   // '9'

    localparam t_kw_mask KW_ALL  = '1;

    // keyword bit numbers
    localparam int unsigned KW_LOCK = 2;
    localparam int unsigned KW_SLP  = 3;
    localparam int unsigned KW_PEO  = 4;
    localparam int unsigned KW_ID   = 5;

    localparam t_byte KW_TEXT [NUM_KW][KW_MAX] = '{
        '{8'h4C, 8'h45, 8'h44, 8'h3A, 8'h31},   // LED:1
        '{8'h4C, 8'h45, 8'h44, 8'h3A, 8'h30},   // LED:0
        '{8'h4C, 8'h4F, 8'h43, 8'h4B, 8'h3A},   // LOCK:
        '{8'h53, 8'h4C, 8'h50, 8'h3A, 8'h00},   // SLP:
        '{8'h50, 8'h45, 8'h4F, 8'h3A, 8'h00},   // PEO:
        '{8'h49, 8'h44, 8'h3A, 8'h00, 8'h00}    // ID:
    };

    localparam t_len KW_LEN [NUM_KW] = '{5'd5, 5'd5, 5'd5, 5'd4, 5'd4, 5'd3};

endpackage

`default_nettype wire

// ===== design/acfd_if.sv =====
// Valid/ready channel interfaces of the frame decoder: received bytes in,
// decoded commands out. Depends on acfd_pkg.
`default_nettype none

interface acfd_byte_if
    import acfd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acfd_cmd_if
    import acfd_pkg::*;
;
    logic   valid;
    logic   ready;
    t_cmd   command;
    t_value value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

// ===== design/ascii_command_frame_decoder_unit.sv =====
// ASCII command frame decoder, top level.
// Depends on acfd_pkg, acfd_if.sv and assert_macros.svh.
//
// Usage:
//   i_rx carries received serial bytes, one item per byte; o_cmd carries one
//   decoded command (command, value) for every frame, a frame ending with
//   and including '#'. Other bytes produce no output item.
//   Each byte is matched against the keywords, the decimal argument is
//   accumulated (one multiply-by-ten and add) and the frame state updated
//   in the cycle it is accepted; the result register is loaded at the same
//   edge that takes the '#', so o_cmd.valid rises in the following cycle.
//   Throughput: one byte every cycle while i_rx.ready is high, set by the
//   update of the frame state feeding itself.
//   Stall: a pending result sits in the output register; i_rx.ready is high
//   while that register is empty or being emptied in the same cycle, so a
//   byte can be taken in the cycle a result leaves.
//   Reset (synchronous, active low): frame state cleared, output empty.
//   MAX_FRAME bytes (the '#' counted) fit in a frame; longer frames give
//   command 0, value 0 at their '#'.
`default_nettype none

`include "assert_macros.svh"

module ascii_command_frame_decoder_unit
    import acfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 20
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    acfd_byte_if.sink     i_rx,
    acfd_cmd_if.source    o_cmd
);

    localparam t_len LAST_POS = LEN_W'(MAX_FRAME - 1);

    t_len     r_len,     n_len;
    t_kw_mask r_alive,   n_alive;
    t_value   r_acc,     n_acc;
    logic     r_ended,   n_ended;
    t_byte    r_lock,    n_lock;
    logic     r_over,    n_over;

    logic     r_out_valid;
    t_cmd     r_out_cmd, n_out_cmd;
    t_value   r_out_val, n_out_val;

    logic     fire;
    logic     fire_mark;
    logic     is_mark;
    logic     is_digit;
    logic     num_open;
    logic [VALUE_W+3:0] acc_prod;
    t_byte    b;

    assign b         = i_rx.rx_byte;
    assign is_mark   = (b == END_MARK);
    assign is_digit  = (b inside {[ASCII_ZERO:ASCII_NINE]});
    assign i_rx.ready = !r_out_valid || o_cmd.ready;
    assign fire      = i_rx.valid && i_rx.ready;
    assign fire_mark = fire && is_mark;

    // numeric argument is open once SLP:, PEO: or ID: has fully matched
    assign num_open = (r_alive[KW_ID] && (r_len >= KW_LEN[KW_ID]))
                   || (r_alive[KW_SLP] && (r_len >= KW_LEN[KW_SLP]))
                   || (r_alive[KW_PEO] && (r_len >= KW_LEN[KW_PEO]));

    // acc * 10 + digit, 36 bits so saturation can be seen
    assign acc_prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + (VALUE_W+4)'(b[3:0] - ASCII_ZERO[3:0]);

    always_comb begin
        n_len   = r_len;
        n_alive = r_alive;
        n_acc   = r_acc;
        n_ended = r_ended;
        n_lock  = r_lock;
        n_over  = r_over;
        if (!r_over) begin
            if (num_open && !r_ended) begin
                if (is_digit) begin
                    n_acc = (acc_prod[VALUE_W+3:VALUE_W] != '0) ? '1
                                                               : acc_prod[VALUE_W-1:0];
                end else begin
                    n_ended = 1'b1;
                end
            end
            if (r_len == LEN_W'(KW_MAX)) begin
                n_lock = b;
            end
            for (int k = 0; k < NUM_KW; k++) begin
                if (r_len < KW_LEN[k] && b != KW_TEXT[k][r_len[2:0]]) begin
                    n_alive[k] = 1'b0;
                end
            end
            if (!is_mark) begin
                if (r_len >= LAST_POS) begin
                    n_over = 1'b1;
                end else begin
                    n_len = r_len + 1'b1;
                end
            end
        end
    end

    // result as seen at the '#': lowest matching keyword wins
    always_comb begin
        n_out_cmd = CMD_BAD;
        n_out_val = '0;
        if (!r_over) begin
            for (int k = NUM_KW - 1; k >= 0; k--) begin
                if (n_alive[k]) begin
                    n_out_cmd = CMD_W'(k + 1);
                end
            end
            case (n_out_cmd)
                CMD_LOCK:                        n_out_val = VALUE_W'(n_lock) - VALUE_W'(ASCII_ZERO);
                CMD_SLEEP, CMD_PEOPLE, CMD_FP_ID: n_out_val = n_acc;
                default:                         n_out_val = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_alive     <= KW_ALL;
            r_acc       <= '0;
            r_ended     <= 1'b0;
            r_lock      <= '0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire_mark) begin
                r_len   <= '0;
                r_alive <= KW_ALL;
                r_acc   <= '0;
                r_ended <= 1'b0;
                r_lock  <= '0;
                r_over  <= 1'b0;
            end else if (fire) begin
                r_len   <= n_len;
                r_alive <= n_alive;
                r_acc   <= n_acc;
                r_ended <= n_ended;
                r_lock  <= n_lock;
                r_over  <= n_over;
            end
            if (fire_mark) begin
                r_out_valid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_mark) begin
            r_out_cmd <= n_out_cmd;
            r_out_val <= n_out_val;
        end
    end

    assign o_cmd.valid   = r_out_valid;
    assign o_cmd.command = r_out_cmd;
    assign o_cmd.value   = r_out_val;

    // a fresh result only ever follows an accepted '#'
    `ACFD_ASSERT(a_out_from_mark,
        (r_out_valid && !$past(r_out_valid && !o_cmd.ready)) |-> $past(fire_mark),
        "result appeared without a frame end")
    `ACFD_ASSERT_ALWAYS(a_len_bound, !i_rst_n || r_len <= LAST_POS,
        "frame length past its limit")
    `ACFD_ASSERT(a_clear_after_mark,
        $past(fire_mark) |-> (r_len == '0 && r_alive == KW_ALL && !r_over && r_acc == '0),
        "frame state not cleared after frame end")
    `ACFD_ASSERT(a_plain_cmd_zero,
        (r_out_valid && r_out_cmd <= CMD_LED_OFF) |-> (r_out_val == '0),
        "nonzero value on a command without argument")

endmodule

`default_nettype wire

// ===== sim/tb_ascii_command_frame_decoder_unit.sv =====
// Self-checking bench for ascii_command_frame_decoder_unit: byte stream in, command items out.
// Depends on acfd_pkg and the channel interfaces in acfd_if.sv.
// A bit-true frame predictor fills a queue of expected commands, which are checked in order.
`default_nettype none

module tb_ascii_command_frame_decoder_unit;
    import acfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_MAX    = 20;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          TAIL_CYCLES  = 8;

    typedef struct packed {
        t_cmd   command;
        t_value value;
    } t_cmd_item;

    typedef t_byte t_byte_q [$];

    bit   i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    acfd_byte_if rx_if ();
    acfd_cmd_if  cmd_if ();

    ascii_command_frame_decoder_unit #(.MAX_FRAME(FRAME_MAX)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_cmd   (cmd_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // keyword order is also priority order
    string kw_word [NUM_KW] = '{"LED:1", "LED:0", "LOCK:", "SLP:", "PEO:", "ID:"};
    t_cmd  kw_cmd  [NUM_KW] = '{CMD_LED_ON, CMD_LED_OFF, CMD_LOCK,
                                CMD_SLEEP, CMD_PEOPLE, CMD_FP_ID};

    // predicted frame state
    t_len     frame_len;
    t_kw_mask kw_live;
    t_value   arg_acc;
    bit       arg_done;
    t_byte    lock_byte;
    bit       frame_overflow;

    t_cmd_item expected_cmds [$];

    int  fail_count     = 0;
    int  bytes_sent     = 0;
    int  frames_sent    = 0;
    int  overlong_count = 0;
    int  cmd_tally [7];
    bit  rx_burst       = 1'b0;
    bit  sink_burst     = 1'b0;

    task automatic clear_frame_state();
        frame_len      = '0;
        kw_live        = KW_ALL;
        arg_acc        = '0;
        arg_done       = 1'b0;
        lock_byte      = '0;
        frame_overflow = 1'b0;
    endtask

    // Advance the frame state by one accepted byte; a '#' yields one expected command.
    task automatic decode_frame_byte(input t_byte b);
        int          pos;
        bit          arg_open;
        logic [63:0] wide;
        t_cmd_item   item;
        pos = frame_len;
        if (!frame_overflow) begin
            arg_open = (kw_live[KW_ID] && pos >= 3) || (kw_live[KW_SLP] && pos >= 4) ||
                       (kw_live[KW_PEO] && pos >= 4);
            if (arg_open && !arg_done) begin
                if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
                    wide = 64'(arg_acc) * 64'd10 + 64'(b - ASCII_ZERO);
                    arg_acc = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
                end else begin
                    arg_done = 1'b1;
                end
            end
            if (pos == 5)
                lock_byte = b;
            for (int k = 0; k < NUM_KW; k++) begin
                if (pos < kw_word[k].len() && b != t_byte'(kw_word[k][pos]))
                    kw_live[k] = 1'b0;
            end
            if (b != END_MARK) begin
                if (pos >= FRAME_MAX - 1)
                    frame_overflow = 1'b1;
                else
                    frame_len = t_len'(pos + 1);
            end
        end
        if (b == END_MARK) begin
            item.command = CMD_BAD;
            item.value   = '0;
            if (!frame_overflow) begin
                for (int k = NUM_KW - 1; k >= 0; k--) begin
                    if (kw_live[k])
                        item.command = kw_cmd[k];
                end
                if (item.command == CMD_LOCK)
                    item.value = t_value'(lock_byte) - t_value'(ASCII_ZERO);
                else if (item.command >= CMD_SLEEP)
                    item.value = arg_acc;
            end else begin
                overlong_count++;
            end
            expected_cmds.push_back(item);
            cmd_tally[item.command]++;
            frames_sent++;
            clear_frame_state();
        end
    endtask

    // Present one byte, after a random gap unless in burst mode, and hold it until taken.
    task automatic push_rx_byte(input t_byte b);
        int gap;
        gap = rx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
        decode_frame_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_rx_byte(t_byte'(s[i]));
    endtask

    task automatic send_bytes(input t_byte_q q);
        foreach (q[i])
            push_rx_byte(q[i]);
    endtask

    task automatic hold_until_drained();
        rx_if.valid <= 1'b0;
        while (expected_cmds.size() > 0)
            @(posedge i_clk);
    endtask

    function automatic t_byte any_but_end();
        t_byte v;
        v = t_byte'($urandom_range(0, 255));
        while (v == END_MARK)
            v = t_byte'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic append_text(inout t_byte_q q, input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(t_byte'(s[i]));
    endtask

    // ---------------- directed tests ----------------

    task automatic test_led_frames();
        send_text("LED:1#");
        send_text("LED:0#");
        send_text("LED:9#");
        send_text("LED:#");            // '#' inside the keyword
        send_text("LED:1:x#");
    endtask

    task automatic test_lock_frames();
        send_text("LOCK:7#");
        send_text("LOCK:#");           // empty argument, captures the '#'
        send_text("LOCK:");
        push_rx_byte(8'hFF);
        push_rx_byte(END_MARK);
        send_text("LOCK:");
        push_rx_byte(8'h00);
        push_rx_byte(END_MARK);
        send_text("LOCK:A99#");
    endtask

    task automatic test_argument_frames();
        send_text("SLP:0#");
        send_text("PEO:4294967295#");
        send_text("ID:4294967296#");   // one past the top, saturates
        send_text("SLP:000123#");
        send_text("ID:#");
        send_text("PEO:-5#");
        send_text("ID: 7#");
        send_text("SLP:+1#");
        send_text("ID:12a34#");
    endtask

    task automatic test_unknown_frames();
        send_text("#");
        send_text("led:1#");
        send_text("XLED:1#");
        send_text("LO#");
        send_bytes('{8'hFF, 8'h00, 8'h80, 8'h7F, END_MARK});
    endtask

    task automatic test_frame_length();
        send_text("ID:1234567890123456#");    // exactly fills the frame
        send_text("ID:12345678901234567#");   // one byte too many
        send_text("LED:1zzzzzzzzzzzzzz#");
        send_text("LED:1zzzzzzzzzzzzzzz#");
        send_text("LED:0#");
        send_text("PEO:1111111111111111111111111111111111111#");
        send_text("PEO:42#");
    endtask

    task automatic test_drain_pause();
        send_text("SLP:77#");
        hold_until_drained();
        send_text("LOCK:5#");
        hold_until_drained();
        send_text("ID:8#");
    endtask

    // ---------------- random frames ----------------

    task automatic random_frame();
        t_byte_q frame;
        int      kind;
        int      n;
        int      cut;
        int      sel;
        string   word;
        bit      nines;
        frame = {};
        kind  = $urandom_range(0, 99);
        if (kind < 12) begin
            append_text(frame, "LED:");
            sel = $urandom_range(0, 19);
            frame.push_back(sel < 9 ? t_byte'("1") : sel < 18 ? t_byte'("0") : any_but_end());
        end else if (kind < 24) begin
            append_text(frame, "LOCK:");
            frame.push_back(t_byte'($urandom_range(0, 255)));
        end else if (kind < 66) begin
            sel = $urandom_range(3, 5);
            append_text(frame, kw_word[sel]);
            nines = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                frame.push_back(nines ? ASCII_NINE : ASCII_ZERO + t_byte'($urandom_range(0, 9)));
            case ($urandom_range(0, 7))
                0: frame.push_back(t_byte'("+"));
                1: frame.push_back(t_byte'("-"));
                2: frame.push_back(t_byte'(" "));
                3, 4: frame.push_back(any_but_end());
                default: ;
            endcase
        end else if (kind < 78) begin
            word = kw_word[$urandom_range(0, NUM_KW - 1)];
            cut  = $urandom_range(1, word.len() - 1);
            append_text(frame, word.substr(0, cut - 1));
            if ($urandom_range(0, 1))
                frame.push_back(any_but_end());
        end else if (kind < 92) begin
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
                frame.push_back(any_but_end());
        end else begin
            if ($urandom_range(0, 1))
                append_text(frame, kw_word[$urandom_range(0, NUM_KW - 1)]);
            n = $urandom_range(19, 28);
            while (frame.size() < n)
                frame.push_back(any_but_end());
        end
        // a LOCK argument may itself have ended the frame
        if (frame.size() == 0 || frame[frame.size() - 1] != END_MARK) begin
            if ($urandom_range(0, 9) < 4) begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    frame.push_back(any_but_end());
            end
            frame.push_back(END_MARK);
        end
        send_bytes(frame);
    endtask

    task automatic test_random_frames();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 24) == 0)
                rx_burst = ~rx_burst;
            if ($urandom_range(0, 24) == 0)
                sink_burst = ~sink_burst;
            random_frame();
        end
    endtask

    // ---------------- result side ----------------

    initial begin : cmd_sink
        int stall;
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                cmd_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            cmd_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(cmd_if.valid === 1'b1 && cmd_if.ready));
        end
    end

    always @(posedge i_clk) begin
        t_cmd_item exp_item;
        if (i_rst_n && cmd_if.valid === 1'b1 && cmd_if.ready) begin
            if (expected_cmds.size() == 0) begin
                $error("unexpected command item: command %0d value %0d",
                       cmd_if.command, cmd_if.value);
                fail_count++;
            end else begin
                exp_item = expected_cmds.pop_front();
                if (cmd_if.command !== exp_item.command) begin
                    $error("command: expected %0d, got %0d", exp_item.command, cmd_if.command);
                    fail_count++;
                end
                if (cmd_if.value !== exp_item.value) begin
                    $error("value: expected %0d, got %0d", exp_item.value, cmd_if.value);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        clear_frame_state();
        foreach (cmd_tally[i])
            cmd_tally[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_led_frames();
        test_lock_frames();
        test_argument_frames();
        test_unknown_frames();
        test_frame_length();
        test_drain_pause();
        test_random_frames();

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Fed %0d bytes in %0d frames (%0d overlong) through random gaps and stalls.",
                 bytes_sent, frames_sent, overlong_count);
        $display("Commands: bad %0d, on %0d, off %0d, lock %0d, sleep %0d, people %0d, id %0d",
                 cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3],
                 cmd_tally[4], cmd_tally[5], cmd_tally[6]);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d commands outstanding", expected_cmds.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
